/* rtl/bsc_pkg.sv */
// shared types, constants and helpers for the barometric compensation block
package bsc_pkg;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // register indexes, byte address is 8 * index
  localparam logic [2:0] REG_A123 = 3'd0;
  localparam logic [2:0] REG_A456 = 3'd1;
  localparam logic [2:0] REG_B12  = 3'd2;
  localparam logic [2:0] REG_MCMD = 3'd3;
  localparam logic [2:0] REG_OSS  = 3'd4;

  localparam logic        KIND_TEMP  = 1'b0;
  localparam logic        KIND_PRESS = 1'b1;

  localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
  localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
  localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
  localparam logic signed [31:0] P_OFFSET    = 32'sd3791;
  localparam logic [31:0]        B7_SCALE    = 32'd50000;
  localparam logic signed [31:0] B4_OFFSET   = 32'sd32768;

  typedef struct packed {
    logic [47:0] a123;
    logic [47:0] a456;
    logic [31:0] b12;
    logic [31:0] mcmd;
    logic [1:0]  oss;
  } coef_t;

  // signed division by 2**k, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                    input logic [4:0] k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = x + bias;
    return $signed(sum) >>> k;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

/* rtl/bsc_regs.sv */
// configuration register file on the apb-style port
module bsc_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsc_pkg::PADDR_W-1:0]      paddr,
  input  logic [bsc_pkg::PDATA_W-1:0]      pwdata,
  output logic [bsc_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  output bsc_pkg::coef_t                   coef
);

  logic [2:0] idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        bsc_pkg::REG_A123: coef.a123 <= pwdata[47:0];
        bsc_pkg::REG_A456: coef.a456 <= pwdata[47:0];
        bsc_pkg::REG_B12:  coef.b12  <= pwdata[31:0];
        bsc_pkg::REG_MCMD: coef.mcmd <= pwdata[31:0];
        bsc_pkg::REG_OSS:  coef.oss  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bsc_pkg::REG_A123: prdata = {16'd0, coef.a123};
      bsc_pkg::REG_A456: prdata = {16'd0, coef.a456};
      bsc_pkg::REG_B12:  prdata = {32'd0, coef.b12};
      bsc_pkg::REG_MCMD: prdata = {32'd0, coef.mcmd};
      bsc_pkg::REG_OSS:  prdata = {62'd0, coef.oss};
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/bsc_div.sv */
// unsigned 32-bit restoring divider, one quotient bit per cycle
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted  = {rem, quo[31]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/baro_sensor_compensation_top.sv */
// top level: sequencer with one shared multiplier and a shared divider
// Barometric sensor compensation.
// Input channel (in_valid / in_stall): one request carries kind and raw_word.
// kind 0 is a temperature reading (low 16 bits of raw_word are UT); the block
// returns temperature in 0.1 degC and keeps B5 for later pressure requests.
// kind 1 is a pressure reading; it uses the last kept B5 and returns Pa.
// Output channel (out_valid / out_stall): one result per request with
// result_kind, value and divide_error (set, with value 0, on a zero divisor).
// Calibration and oversampling sit in the apb-style registers; the user must write
// them only while the block is idle, and the block itself does not enforce this.
// One request at a time. The result of a request is offered once the sequencer
// steps and the bit-serial divider are through; the shared 32x32 multiplier
// serves the sequencer steps, and a zero divisor skips the divider.
// in_stall is high from acceptance until the result is handed to the output
// register, so a new request is taken only after the last one is handed over.
// A stalled output holds its result; the next request can be accepted while
// the result waits, but its own result waits until the output is free.
// Reset clears the registers, the kept B5 and the output valid.
module baro_sensor_compensation_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsc_pkg::PADDR_W-1:0] paddr,
  input  logic [bsc_pkg::PDATA_W-1:0] pwdata,
  output logic [bsc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [23:0]                 raw_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        result_kind,
  output logic signed [31:0]          value,
  output logic                        divide_error
);

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_TDIV,
    S_B6, S_SQ, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_PDIV,
    S_Q1, S_Q2, S_Q3, S_Q4, S_FIN
  } state_t;

  state_t state;
  bsc_pkg::coef_t coef;

  // coefficient fields
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5, ac6;

  // request and working registers
  logic               kind_q;
  logic [23:0]        raw_q;
  logic signed [31:0] temp_int;
  logic [31:0]        prod;
  logic signed [31:0] b6, sq, t1, t2, b3, x3v, p;
  logic [31:0]        b4;
  logic               neg_q, dbl_q;
  logic signed [31:0] res_value;
  logic               res_err;

  // shared multiplier, low 32 bits of the product
  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_full;

  // divider
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;

  // combinational helpers
  logic signed [31:0] ut, x1_t, den, mc_sh, b5, x1_p, x3_p, b3_raw, b3_sh;
  logic signed [31:0] up, pd, x2_p, pu_s;
  logic [31:0]        b7, pu, q_signed;

  bsc_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef   (coef)
  );

  bsc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_a),
    .divisor (div_b),
    .done    (div_done),
    .quotient(div_q)
  );

  assign ac1 = {{16{coef.a123[47]}}, coef.a123[47:32]};
  assign ac2 = {{16{coef.a123[31]}}, coef.a123[31:16]};
  assign ac3 = {{16{coef.a123[15]}}, coef.a123[15:0]};
  assign ac4 = {16'd0, coef.a456[47:32]};
  assign ac5 = {16'd0, coef.a456[31:16]};
  assign ac6 = {16'd0, coef.a456[15:0]};
  assign b1  = {{16{coef.b12[31]}}, coef.b12[31:16]};
  assign b2  = {{16{coef.b12[15]}}, coef.b12[15:0]};
  assign mc  = {{16{coef.mcmd[31]}}, coef.mcmd[31:16]};
  assign md  = {{16{coef.mcmd[15]}}, coef.mcmd[15:0]};

  assign in_stall = (state != S_IDLE);
  assign mul_full = mul_a * mul_b;

  always_comb begin
    // temperature path
    ut    = {16'd0, raw_q[15:0]};
    x1_t  = bsc_pkg::sdiv_pow2(prod, 5'd15);
    den   = t1 + md;
    mc_sh = mc <<< 11;
    q_signed = neg_q ? (~div_q + 32'd1) : div_q;
    b5    = t1 + q_signed;
    // pressure path
    x1_p   = bsc_pkg::sdiv_pow2(prod, 5'd11);
    b3_raw = (ac1 <<< 2) + x1_p + t2;
    b3_sh  = b3_raw << coef.oss;
    x3_p   = bsc_pkg::sdiv_pow2(t1 + bsc_pkg::sdiv_pow2(prod, 5'd16) + 32'sd2, 5'd2);
    up     = {8'd0, raw_q >> (4'd8 - {2'd0, coef.oss})};
    b7     = prod;
    pu     = dbl_q ? {div_q[30:0], 1'b0} : div_q;
    pu_s   = pu;
    pd     = bsc_pkg::sdiv_pow2(p, 5'd8);
    x2_p   = bsc_pkg::sdiv_pow2(prod, 5'd16);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_T0: begin mul_a = ut - ac6;  mul_b = ac5; end
      S_SQ: begin mul_a = b6;        mul_b = b6;  end
      S_M1: begin mul_a = ac2;       mul_b = b6;  end
      S_M2: begin mul_a = b2;        mul_b = sq;  end
      S_M3: begin mul_a = ac3;       mul_b = b6;  end
      S_M4: begin mul_a = b1;        mul_b = sq;  end
      S_M6: begin mul_a = ac4;       mul_b = x3v; end
      S_M7: begin mul_a = up - b3;   mul_b = bsc_pkg::B7_SCALE >> coef.oss; end
      S_Q1: begin mul_a = pd;        mul_b = pd;  end
      S_Q2: begin mul_a = prod;      mul_b = bsc_pkg::P_COEF_SQ; end
      S_Q3: begin mul_a = bsc_pkg::P_COEF_LIN; mul_b = p; end
      default: ;
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state)
      S_T2: begin
        div_start = (den != 32'sd0);
        div_a     = bsc_pkg::mag32(mc_sh);
        div_b     = bsc_pkg::mag32(den);
      end
      S_M8: begin
        div_start = (b4 != 32'd0);
        div_a     = b7[31] ? b7 : {b7[30:0], 1'b0};
        div_b     = b4;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_full;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      temp_int  <= '0;
    end else begin
      // the final state reloads the output itself when it is free
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            raw_q  <= raw_word;
            state  <= (kind == bsc_pkg::KIND_TEMP) ? S_T0 : S_B6;
          end
        end
        // temperature
        S_T0: state <= S_T1;
        S_T1: begin
          t1    <= x1_t;
          state <= S_T2;
        end
        S_T2: begin
          neg_q <= mc_sh[31] ^ den[31];
          if (den == 32'sd0) begin
            res_value <= '0;
            res_err   <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            temp_int  <= b5;
            res_value <= bsc_pkg::sdiv_pow2(b5 + 32'sd8, 5'd4);
            res_err   <= 1'b0;
            state     <= S_FIN;
          end
        end
        // pressure
        S_B6: begin
          b6    <= temp_int - bsc_pkg::B6_OFFSET;
          state <= S_SQ;
        end
        S_SQ: state <= S_M1;
        S_M1: begin
          sq    <= bsc_pkg::sdiv_pow2(prod, 5'd12);
          state <= S_M2;
        end
        S_M2: begin
          t2    <= x1_p;                      // ac2 * b6 / 2048
          state <= S_M3;
        end
        S_M3: begin
          b3    <= bsc_pkg::sdiv_pow2(b3_sh + 32'sd2, 5'd2);
          state <= S_M4;
        end
        S_M4: begin
          t1    <= bsc_pkg::sdiv_pow2(prod, 5'd13);
          state <= S_M5;
        end
        S_M5: begin
          x3v   <= x3_p + bsc_pkg::B4_OFFSET;
          state <= S_M6;
        end
        S_M6: state <= S_M7;
        S_M7: begin
          b4    <= prod >> 15;
          state <= S_M8;
        end
        S_M8: begin
          neg_q <= 1'b0;
          dbl_q <= b7[31];
          if (b4 == 32'd0) begin
            res_value <= '0;
            res_err   <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            p     <= pu_s;
            state <= S_Q1;
          end
        end
        S_Q1: state <= S_Q2;
        S_Q2: state <= S_Q3;
        S_Q3: begin
          t1    <= x2_p;                      // x1 * 3038 / 65536
          state <= S_Q4;
        end
        S_Q4: begin
          res_value <= p + bsc_pkg::sdiv_pow2(t1 + x2_p + bsc_pkg::P_OFFSET, 5'd4);
          res_err   <= 1'b0;
          state     <= S_FIN;
        end
        // hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            result_kind  <= kind_q;
            value        <= res_value;
            divide_error <= res_err;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
